/* hdl/assert_macros.svh */
// Assertion macros used by the datapath RTL file of the rank/unrank block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on aclk outside reset.
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset.
`define ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/ddru_pkg.sv */
// Package: widths, codes, states and control structs of the rank/unrank block.
package ddru_pkg;

    localparam int DATA_W  = 64;
    localparam int BOUND_W = 63;
    localparam int BASE_W  = 8;
    localparam int CFG_W   = 63;

    // Digit steps the divider retires per cycle
    localparam int DIV_STEPS = 8;
    localparam int DIV_CYC   = DATA_W / DIV_STEPS;
    localparam int DIV_CW    = $clog2(DIV_CYC);

    localparam logic [BASE_W-1:0] BASE_RESET = 8'd2;
    localparam logic [BASE_W-1:0] BASE_MIN   = 8'd2;

    // Configuration register indexes
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_BOUND = 1'b1;

    // Opcodes
    localparam logic OP_QUERY  = 1'b0;
    localparam logic OP_UNRANK = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SDIV,
        S_SWAIT,
        S_SMUL,
        S_SACC,
        S_WINIT,
        S_WRD,
        S_WDIV,
        S_WWAIT,
        S_WMUL,
        S_WACC,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic div_start;
        logic split_phase;
        logic mul;
        logic split_acc;
        logic walk_init;
        logic walk_acc;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic stale;
        logic div_done;
        logic split_last;
        logic walk_last;
        logic out_free;
    } stat_t;

endpackage

/* hdl/ddru_div.sv */
// Iterative divider: 64-bit dividend by 8-bit divisor, eight quotient bits per cycle while busy.
module ddru_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ddru_pkg::DATA_W-1:0] dividend,
    input  logic [ddru_pkg::BASE_W-1:0] divisor,
    output logic                        done,
    output logic [ddru_pkg::DATA_W-1:0] quotient,
    output logic [ddru_pkg::BASE_W-1:0] remainder
);
    import ddru_pkg::*;

    logic [DATA_W-1:0]    quo_reg;
    logic [BASE_W-1:0]    rem_reg;
    logic [BASE_W-1:0]    dvs_reg;
    logic [DIV_CW-1:0]    cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [BASE_W-1:0]    rem_next;
    logic [DIV_STEPS-1:0] qbits;
    logic [BASE_W:0]      r9;

    // Restoring steps over the top bits of the shifting dividend
    always_comb begin
        rem_next = rem_reg;
        qbits    = '0;
        r9       = '0;
        for (int k = 0; k < DIV_STEPS; k++) begin
            r9 = {rem_next, quo_reg[DATA_W-1-k]};
            if (r9 >= {1'b0, dvs_reg}) begin
                r9 = r9 - {1'b0, dvs_reg};
                qbits[DIV_STEPS-1-k] = 1'b1;
            end
            rem_next = r9[BASE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + DIV_CW'(1);
                if (cnt_reg == DIV_CW'(DIV_CYC - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Payload: dividend shifts out as quotient bits shift in
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DATA_W-DIV_STEPS-1:0], qbits};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* hdl/ddru_ctrl.sv */
// Controller: sequences bound digit split, digit walk and result load.
module ddru_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ddru_pkg::stat_t     stat,
    output ddru_pkg::cmd_t      cmd
);
    import ddru_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = stat.stale ? S_SDIV : S_WINIT;
                end
            end
            S_SDIV:  state_next = S_SWAIT;
            S_SWAIT: begin
                if (stat.div_done) begin
                    state_next = S_SMUL;
                end
            end
            S_SMUL:  state_next = S_SACC;
            S_SACC:  state_next = stat.split_last ? S_WINIT : S_SDIV;
            S_WINIT: state_next = S_WRD;
            S_WRD:   state_next = S_WDIV;
            S_WDIV:  state_next = S_WWAIT;
            S_WWAIT: begin
                if (stat.div_done) begin
                    state_next = S_WMUL;
                end
            end
            S_WMUL:  state_next = S_WACC;
            S_WACC:  state_next = stat.walk_last ? S_OUT : S_WRD;
            S_OUT: begin
                if (stat.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            S_SDIV: begin
                cmd.div_start   = 1'b1;
                cmd.split_phase = 1'b1;
            end
            S_SMUL: begin
                cmd.mul         = 1'b1;
                cmd.split_phase = 1'b1;
            end
            S_SACC:  cmd.split_acc = 1'b1;
            S_WINIT: cmd.walk_init = 1'b1;
            S_WDIV:  cmd.div_start = 1'b1;
            S_WMUL:  cmd.mul       = 1'b1;
            S_WACC:  cmd.walk_acc  = 1'b1;
            S_OUT:   cmd.out_load  = stat.out_free;
            default: cmd = '0;
        endcase
    end

endmodule

/* hdl/ddru_dpath.sv */
// Datapath: config registers, digit store, divider, products and result register.
`include "assert_macros.svh"

module ddru_dpath #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [ddru_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_opcode,
    input  logic [ddru_pkg::DATA_W-1:0]  s_operand,
    input  ddru_pkg::cmd_t               cmd,
    output ddru_pkg::stat_t              stat,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_member,
    output logic [ddru_pkg::DATA_W-1:0]  m_prefix_count,
    output logic [ddru_pkg::BOUND_W-1:0] m_result_value,
    output logic [ddru_pkg::DATA_W-1:0]  m_total_count
);
    import ddru_pkg::*;

    localparam int LENW = $clog2(MAX_DIGITS + 1);
    localparam int IDXW = $clog2(MAX_DIGITS);

    logic [BASE_W-1:0]  base_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic               stale_reg;

    logic               op_reg;
    logic [DATA_W-1:0]  opnd_reg;
    logic [DATA_W-1:0]  v_reg;
    logic [DATA_W-1:0]  place_reg;
    logic [DATA_W-1:0]  w_reg;
    logic [BOUND_W-1:0] meff_reg;
    logic [DATA_W-1:0]  total_reg;
    logic [LENW-1:0]    len_reg;
    logic [LENW-1:0]    idx_reg;
    logic [DATA_W-1:0]  mpre_reg;
    logic [DATA_W-1:0]  cnt_reg;
    logic [DATA_W-1:0]  val_reg;
    logic               hit_reg;

    logic [DATA_W-1:0]  pa_reg;
    logic [DATA_W-1:0]  pb_reg;
    logic [DATA_W-1:0]  pm_reg;
    logic [DATA_W-1:0]  pw_reg;
    logic [DATA_W-1:0]  pp_reg;

    logic [BASE_W-1:0]  md_mem [MAX_DIGITS];
    logic [BASE_W-1:0]  md_rd_reg;

    logic               m_valid_reg;
    logic               m_member_reg;
    logic [DATA_W-1:0]  m_prefix_reg;
    logic [BOUND_W-1:0] m_value_reg;
    logic [DATA_W-1:0]  m_total_reg;

    logic [BASE_W-1:0]  p_eff;
    logic [BASE_W-1:0]  div_dvs;
    logic [DATA_W-1:0]  div_q;
    logic [BASE_W-1:0]  div_r;
    logic               div_done;
    logic [BASE_W-1:0]  md_sel;
    logic [DATA_W-1:0]  clamp_v;
    logic               n_in_range;

    // Config registers; any write invalidates the cached bound digits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= BASE_RESET;
            bound_reg <= '0;
            stale_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            stale_reg <= 1'b1;
            if (cfg_index == CFG_BASE) begin
                base_reg <= cfg_data[BASE_W-1:0];
            end else begin
                bound_reg <= cfg_data[BOUND_W-1:0];
            end
        end else if (cmd.walk_init) begin
            stale_reg <= 1'b0;
        end
    end

    assign p_eff      = (base_reg < BASE_MIN) ? BASE_MIN : base_reg;
    assign n_in_range = opnd_reg <= {1'b0, meff_reg};
    assign clamp_v    = n_in_range ? opnd_reg : {1'b0, meff_reg};

    // Unrank walks the mixed radix (bound digit + 1); everything else divides by the base
    assign div_dvs = (!cmd.split_phase && op_reg == OP_UNRANK) ?
                     (md_rd_reg + BASE_W'(1)) : p_eff;

    ddru_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (v_reg),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign md_sel = cmd.split_phase ? div_r : md_rd_reg;

    // Digit products, registered before accumulation
    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            pa_reg <= w_reg * {{(DATA_W-BASE_W){1'b0}}, div_r};
            pb_reg <= place_reg * {{(DATA_W-BASE_W){1'b0}}, div_r};
            pm_reg <= place_reg * {{(DATA_W-BASE_W){1'b0}}, md_sel};
            pw_reg <= w_reg * ({{(DATA_W-BASE_W){1'b0}}, md_sel} + DATA_W'(1));
            pp_reg <= place_reg * {{(DATA_W-BASE_W){1'b0}}, p_eff};
        end
    end

    // Bound digit store
    always_ff @(posedge aclk) begin
        if (cmd.split_acc) begin
            md_mem[len_reg[IDXW-1:0]] <= div_r;
        end
    end

    always_ff @(posedge aclk) begin
        md_rd_reg <= md_mem[idx_reg[IDXW-1:0]];
    end

    // Split and walk accumulators; split state is kept while the digits are current
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg    <= s_opcode;
            opnd_reg  <= s_operand;
            if (stale_reg) begin
                v_reg     <= {1'b0, bound_reg};
                len_reg   <= '0;
                place_reg <= DATA_W'(1);
                w_reg     <= DATA_W'(1);
                meff_reg  <= '0;
            end
        end else if (cmd.split_acc) begin
            v_reg     <= div_q;
            len_reg   <= len_reg + LENW'(1);
            place_reg <= pp_reg;
            w_reg     <= pw_reg;
            meff_reg  <= meff_reg + pm_reg[BOUND_W-1:0];
            total_reg <= pw_reg;
        end else if (cmd.walk_init) begin
            v_reg     <= (op_reg == OP_UNRANK) ? opnd_reg : clamp_v;
            idx_reg   <= '0;
            place_reg <= DATA_W'(1);
            w_reg     <= DATA_W'(1);
            mpre_reg  <= '0;
            cnt_reg   <= DATA_W'(1);
            val_reg   <= '0;
            hit_reg   <= 1'b0;
        end else if (cmd.walk_acc) begin
            v_reg     <= div_q;
            idx_reg   <= idx_reg + LENW'(1);
            place_reg <= pp_reg;
            w_reg     <= pw_reg;
            mpre_reg  <= mpre_reg + pm_reg;
            if (op_reg == OP_QUERY && div_r > md_rd_reg) begin
                // Digit above the bound: lower part snaps to bound digits
                hit_reg <= 1'b1;
                cnt_reg <= pw_reg;
                val_reg <= mpre_reg + pm_reg;
            end else begin
                cnt_reg <= cnt_reg + pa_reg;
                val_reg <= val_reg + pb_reg;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_member_reg <= (op_reg == OP_UNRANK) ? 1'b1 : (n_in_range && !hit_reg);
            m_prefix_reg <= (op_reg == OP_UNRANK) ? '0 : cnt_reg;
            m_value_reg  <= val_reg[BOUND_W-1:0];
            m_total_reg  <= total_reg;
        end
    end

    assign stat.stale      = stale_reg;
    assign stat.div_done   = div_done;
    assign stat.split_last = (div_q == '0) || (len_reg == LENW'(MAX_DIGITS - 1));
    assign stat.walk_last  = (idx_reg + LENW'(1)) == len_reg;
    assign stat.out_free   = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_is_member    = m_member_reg;
    assign m_prefix_count = m_prefix_reg;
    assign m_result_value = m_value_reg;
    assign m_total_count  = m_total_reg;

    `ASSERT_IMP(a_split_len, cmd.split_acc, len_reg < LENW'(MAX_DIGITS), "digit store overrun")
    `ASSERT_IMP(a_unrank_digit, cmd.walk_acc && op_reg == OP_UNRANK, div_r <= md_rd_reg, "bad digit")
    `ASSERT_IMP(a_total_nz, m_valid_reg, m_total_reg != '0, "zero total count")
    `ASSERT_NXT(a_out_load, cmd.out_load, m_valid_reg, "result not presented after load")

endmodule

/* hdl/digit_dominance_rank_unrank_top.sv */
// Top level of the digit-dominance rank/unrank block.
//
//  channel   direction  ports                                             handshake
//  s_        in         s_opcode, s_operand                               s_valid / s_ready
//  m_        out        m_is_member, m_prefix_count, m_result_value,
//                       m_total_count                                     m_valid / m_ready
//  cfg_      in         cfg_index, cfg_data                               cfg_wr_en
//
// An item walks the D digits of the bound (D = base-p digits of the bound, up to
// MAX_DIGITS): one shared divider retires 8 bits a cycle while busy, and each digit takes
// a digit read, a divider start, the divide, a product and an accumulate step. After reset
// or a config write the first item also splits the bound into digits; later items reuse
// the stored digits.
// Reset is synchronous, active low. Items on s_ are taken only when the block is idle; a result
// waiting on m_ready does not block the next item, only the load of its result.
module digit_dominance_rank_unrank_top #(
    parameter int MAX_DIGITS = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [ddru_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [ddru_pkg::DATA_W-1:0]  s_operand,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_is_member,
    output logic [ddru_pkg::DATA_W-1:0]  m_prefix_count,
    output logic [ddru_pkg::BOUND_W-1:0] m_result_value,
    output logic [ddru_pkg::DATA_W-1:0]  m_total_count
);
    import ddru_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    ddru_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    ddru_dpath #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dpath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_opcode       (s_opcode),
        .s_operand      (s_operand),
        .cmd            (cmd),
        .stat           (stat),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_is_member    (m_is_member),
        .m_prefix_count (m_prefix_count),
        .m_result_value (m_result_value),
        .m_total_count  (m_total_count)
    );

endmodule

/* verif/ddru_scoreboard.sv */
// Checker for the rank/unrank block: predicts each result and compares it.
module ddru_scoreboard (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic                         cfg_index,
    input  logic [ddru_pkg::CFG_W-1:0]   cfg_data,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic                         s_opcode,
    input  logic [ddru_pkg::DATA_W-1:0]  s_operand,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic                         m_is_member,
    input  logic [ddru_pkg::DATA_W-1:0]  m_prefix_count,
    input  logic [ddru_pkg::BOUND_W-1:0] m_result_value,
    input  logic [ddru_pkg::DATA_W-1:0]  m_total_count,
    output int                           fail_count,
    output int                           pending,
    output int                           checked
);
    import ddru_pkg::*;

    typedef struct packed {
        logic               is_member;
        logic [DATA_W-1:0]  prefix_count;
        logic [BOUND_W-1:0] result_value;
        logic [DATA_W-1:0]  total_count;
    } rank_result_t;

    rank_result_t       expected_results[$];
    logic [BASE_W-1:0]  radix_reg;
    logic [BOUND_W-1:0] bound_reg;

    // Digit split of the bound, weights, then query or unrank walk (64-bit wrap).
    function automatic rank_result_t predict_rank(logic op, logic [63:0] opd);
        logic [63:0] md [64];
        logic [63:0] nd [64];
        logic [63:0] wt [64];
        logic [63:0] p, v, meff, place, w, c, cnt, val, r, radix, d;
        int          len, h, i;
        rank_result_t res;
        p     = (radix_reg < 2) ? 64'd2 : 64'(radix_reg);
        v     = 64'(bound_reg);
        meff  = 0;
        place = 1;
        w     = 1;
        len   = 0;
        cnt   = 0;
        val   = 0;
        h     = -1;
        while (v > 0 && len < 64) begin
            md[len] = v % p;
            v = v / p;
            len++;
        end
        if (len == 0) begin
            md[0] = 0;
            len = 1;
        end
        for (i = 0; i < len; i++) begin
            meff  = meff + md[i] * place;
            place = place * p;
            wt[i] = w;
            w     = w * (md[i] + 1);
        end
        res.total_count = w;
        if (op == OP_QUERY) begin
            c = (opd > meff) ? meff : opd;
            v = c;
            for (i = 0; i < len; i++) begin
                nd[i] = v % p;
                v = v / p;
            end
            for (i = len - 1; i >= 0; i--) begin
                if (nd[i] > md[i]) begin
                    h = i;
                    break;
                end
            end
            res.is_member = (opd <= meff) && (h < 0);
            place = 1;
            if (h < 0) begin
                cnt = 1;
                for (i = 0; i < len; i++) begin
                    cnt   = cnt + nd[i] * wt[i];
                    val   = val + nd[i] * place;
                    place = place * p;
                end
            end else begin
                for (i = 0; i < len; i++) begin
                    d = (i > h) ? nd[i] : md[i];
                    if (i > h)
                        cnt = cnt + nd[i] * wt[i];
                    val   = val + d * place;
                    place = place * p;
                end
                cnt = cnt + (md[h] + 1) * wt[h];
            end
            res.prefix_count = cnt;
        end else begin
            r     = opd % w;
            place = 1;
            for (i = 0; i < len; i++) begin
                radix = md[i] + 1;
                val   = val + (r % radix) * place;
                r     = r / radix;
                place = place * p;
            end
            res.is_member    = 1'b1;
            res.prefix_count = 0;
        end
        res.result_value = val[BOUND_W-1:0];
        return res;
    endfunction

    assign pending = expected_results.size();

    // Results are popped before the new item is queued: an item taken on this
    // edge cannot have its result out on the same edge.
    always @(posedge aclk) begin
        rank_result_t exp_r;
        if (!aresetn) begin
            radix_reg  <= BASE_RESET;
            bound_reg  <= '0;
            fail_count <= 0;
            checked    <= 0;
            expected_results.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_BASE)
                    radix_reg <= cfg_data[BASE_W-1:0];
                else
                    bound_reg <= cfg_data[BOUND_W-1:0];
            end
            if (m_valid && m_ready) begin
                checked <= checked + 1;
                if (expected_results.size() == 0) begin
                    $error("result item with no expectation waiting");
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (m_is_member !== exp_r.is_member ||
                        m_prefix_count !== exp_r.prefix_count ||
                        m_result_value !== exp_r.result_value ||
                        m_total_count !== exp_r.total_count)
                        fail_count <= fail_count + 1;
                    if (m_is_member !== exp_r.is_member)
                        $error("is_member: expected %0d, got %0d",
                               exp_r.is_member, m_is_member);
                    if (m_prefix_count !== exp_r.prefix_count)
                        $error("prefix_count: expected %0d, got %0d",
                               exp_r.prefix_count, m_prefix_count);
                    if (m_result_value !== exp_r.result_value)
                        $error("result_value: expected %0d, got %0d",
                               exp_r.result_value, m_result_value);
                    if (m_total_count !== exp_r.total_count)
                        $error("total_count: expected %0d, got %0d",
                               exp_r.total_count, m_total_count);
                end
            end
            if (s_valid && s_ready)
                expected_results.insert(expected_results.size(),
                                        predict_rank(s_opcode, s_operand));
        end
    end

endmodule

/* verif/tb_digit_dominance_rank_unrank_top.sv */
// Testbench top: clock, reset, stimulus, back-pressure and verdict for the rank/unrank block.
module tb_digit_dominance_rank_unrank_top;
    import ddru_pkg::*;

    localparam int IDLE_LIMIT = 30000;
    localparam int LONG_HOLD  = 3000;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = CFG_BASE;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_opcode = OP_QUERY;
    logic [DATA_W-1:0]    s_operand = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic                 m_is_member;
    logic [DATA_W-1:0]    m_prefix_count;
    logic [BOUND_W-1:0]   m_result_value;
    logic [DATA_W-1:0]    m_total_count;
    int                   fail_count, pending, checked;
    int                   items_sent = 0;
    int                   configs_used = 0;
    int                   idle_cycles = 0;
    logic                 hold_request = 1'b0;
    logic [BOUND_W-1:0]   cur_bound = '0;

    always #2 aclk = ~aclk;

    digit_dominance_rank_unrank_top dut (.*);

    ddru_scoreboard rank_checker (.*);

    // Watchdog on cycles where neither channel moves an item
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: random ready bursts and stalls, one long hold on request
    initial begin
        int len;
        @(posedge aresetn);
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_request = 1'b0;
            end
            len = $urandom_range(1, 30);
            m_ready <= 1'b1;
            repeat (len) @(posedge aclk);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 4);
            if (len > 0) begin
                m_ready <= 1'b0;
                repeat (len) @(posedge aclk);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Offer one item; valid stays up across back-to-back items.
    // Ready is looked at mid-cycle, where it is settled for the coming edge.
    task automatic send_item(logic op, logic [63:0] opd);
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 :
              (($urandom_range(0, 14) == 0) ? $urandom_range(10, 80) : $urandom_range(1, 3));
        if (gap > 0 && s_valid) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_opcode  <= op;
        s_operand <= opd;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    // Register write only once every result is back
    task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
        if (s_valid) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_BOUND)
            cur_bound = val[BOUND_W-1:0];
        configs_used++;
    endtask

    // Random item: query or unrank of a wild operand, one near the bound, or one within it
    task automatic random_item();
        logic [63:0] opd;
        case ($urandom_range(0, 5))
            0: opd = rand64();
            1: opd = 64'(cur_bound) - $urandom_range(0, 3);
            2: opd = 64'(cur_bound) + $urandom_range(0, 3);
            default: opd = (cur_bound == 0) ? 64'($urandom_range(0, 3)) :
                           rand64() % (64'(cur_bound) + 1);
        endcase
        send_item($urandom_range(0, 1) ? OP_UNRANK : OP_QUERY, opd);
    endtask

    initial begin
        logic [62:0] b;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset config (base 2, zero bound), then base 10
        send_item(OP_QUERY, 64'd0);
        send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_UNRANK, 64'd5);
        write_reg(CFG_BASE, 63'd10);
        write_reg(CFG_BOUND, 63'd4072);
        send_item(OP_QUERY, 64'd0);
        send_item(OP_QUERY, 64'd4072);
        send_item(OP_QUERY, 64'd4073);
        send_item(OP_QUERY, 64'd3999);
        send_item(OP_QUERY, 64'd1234);
        send_item(OP_QUERY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(OP_UNRANK, 64'd0);
        send_item(OP_UNRANK, 64'd239);
        send_item(OP_UNRANK, 64'd240);
        send_item(OP_UNRANK, 64'hFFFF_FFFF_FFFF_FFFF);
        // Bases below two behave as two; full-width bound
        write_reg(CFG_BASE, 63'd0);
        write_reg(CFG_BOUND, {63{1'b1}});
        send_item(OP_QUERY, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_QUERY, 64'h8000_0000_0000_0000);
        send_item(OP_UNRANK, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_BASE, 63'd1);
        write_reg(CFG_BOUND, 63'h2AAA_AAAA_AAAA_AAAA);
        send_item(OP_QUERY, 64'h5555_5555_5555_5555);
        send_item(OP_UNRANK, 64'd12345);
        write_reg(CFG_BASE, 63'd255);
        write_reg(CFG_BOUND, 63'h7FFF_FFFF_FFFF_FFFF);
        send_item(OP_QUERY, 64'h1234_5678_9ABC_DEF0);
        send_item(OP_UNRANK, 64'hFEDC_BA98_7654_3210);

        // Random phases; big bounds only now and then to keep the run short
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(CFG_BASE, 63'($urandom_range(0, 3) == 0 ?
                                    $urandom_range(0, 255) : $urandom_range(2, 16)));
            b = 63'({$urandom, $urandom});
            b = (ph % 4 == 3) ? b : (b >> $urandom_range(30, 62));
            write_reg(CFG_BOUND, 63'(b));
            for (int k = 0; k < 68; k++) begin
                if (ph == 4 && k == 10)
                    hold_request = 1'b1;
                random_item();
            end
        end
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("Sent %0d items across %0d register writes; %0d results checked.",
                 items_sent, configs_used, checked);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/ddru_pkg.sv
hdl/ddru_div.sv
hdl/ddru_ctrl.sv
hdl/ddru_dpath.sv
hdl/digit_dominance_rank_unrank_top.sv
verif/ddru_scoreboard.sv
verif/tb_digit_dominance_rank_unrank_top.sv
